/* rtl/text_cursor_number_formatter_assert.svh */
// Assertion macros for the text cursor number formatter.
// They expect aclk and aresetn to be in scope where they are used.
`ifndef TEXT_CURSOR_NUMBER_FORMATTER_ASSERT_SVH
`define TEXT_CURSOR_NUMBER_FORMATTER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TCNF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("tcnf: invariant violated");

// A condition that must hold in the cycle after a trigger.
`define TCNF_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("tcnf: sequence violated");

`endif

/* rtl/tcnf_pkg.sv */
`default_nettype none

package tcnf_pkg;

    // Action codes of an input word.
    localparam logic [2:0] ACT_CHAR    = 3'd0;
    localparam logic [2:0] ACT_NEWLINE = 3'd1;
    localparam logic [2:0] ACT_SDEC    = 3'd2;
    localparam logic [2:0] ACT_UDEC    = 3'd3;
    localparam logic [2:0] ACT_SHEX    = 3'd4;
    localparam logic [2:0] ACT_UHEX    = 3'd5;

    localparam logic [7:0] GLYPH_ZERO  = 8'h30;
    localparam logic [7:0] GLYPH_A     = 8'h61;
    localparam logic [7:0] GLYPH_MINUS = 8'h2d;

    // Last digit positions of the two number forms.
    localparam logic [3:0] DEC_LAST_POS = 4'd9;
    localparam logic [3:0] HEX_LAST_POS = 4'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  char_code;
        logic [31:0] number_value;
        logic        newline_after;
    } in_word_t;

    typedef struct packed {
        logic [8:0]  draw_x;
        logic [15:0] draw_y;
        logic [7:0]  glyph;
        logic        last_of_run;
    } out_word_t;

    // Datapath operations selected by the microcode.
    typedef enum logic [2:0] {
        OP_FETCH,
        OP_CHAR,
        OP_NEWLINE,
        OP_SIGN,
        OP_DEC,
        OP_HEX,
        OP_FINISH
    } op_t;

    // Sequencing rule of a microcode step.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_GOTO,
        COND_DISPATCH,
        COND_IF_HEX,
        COND_LOOP
    } cond_t;

    typedef logic [2:0] uaddr_t;

    localparam uaddr_t UA_FETCH   = 3'd0;
    localparam uaddr_t UA_CHAR    = 3'd1;
    localparam uaddr_t UA_NEWLINE = 3'd2;
    localparam uaddr_t UA_SIGN    = 3'd3;
    localparam uaddr_t UA_DEC     = 3'd4;
    localparam uaddr_t UA_HEX     = 3'd5;
    localparam uaddr_t UA_FINISH  = 3'd6;

    typedef struct packed {
        op_t    op;
        cond_t  cond;
        uaddr_t target;
    } uword_t;

    // Sequencer to datapath.
    typedef struct packed {
        op_t op;
    } tcnf_ctrl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic       stall;
        logic       done;
        logic       is_hex;
        logic [2:0] action;
    } tcnf_stat_t;

    function automatic uword_t ucode_rom(input uaddr_t addr);
        uword_t w;
        unique case (addr)
            UA_FETCH:   w = '{OP_FETCH,   COND_DISPATCH, UA_FETCH};
            UA_CHAR:    w = '{OP_CHAR,    COND_GOTO,     UA_FINISH};
            UA_NEWLINE: w = '{OP_NEWLINE, COND_GOTO,     UA_FETCH};
            UA_SIGN:    w = '{OP_SIGN,    COND_IF_HEX,   UA_HEX};
            UA_DEC:     w = '{OP_DEC,     COND_LOOP,     UA_FINISH};
            UA_HEX:     w = '{OP_HEX,     COND_LOOP,     UA_FINISH};
            UA_FINISH:  w = '{OP_FINISH,  COND_GOTO,     UA_FETCH};
            default:    w = '{OP_FETCH,   COND_GOTO,     UA_FETCH};
        endcase
        return w;
    endfunction

    function automatic uaddr_t dispatch(input logic [2:0] action);
        uaddr_t a;
        unique case (action) inside
            ACT_CHAR:                               a = UA_CHAR;
            ACT_NEWLINE:                            a = UA_NEWLINE;
            ACT_SDEC, ACT_UDEC, ACT_SHEX, ACT_UHEX: a = UA_SIGN;
            default:                                a = UA_FETCH;
        endcase
        return a;
    endfunction

    // Weight of decimal digit position 0 (billions) to 9 (units).
    function automatic logic [31:0] pow10(input logic [3:0] pos);
        logic [31:0] w;
        unique case (pos)
            4'd0:    w = 32'd1000000000;
            4'd1:    w = 32'd100000000;
            4'd2:    w = 32'd10000000;
            4'd3:    w = 32'd1000000;
            4'd4:    w = 32'd100000;
            4'd5:    w = 32'd10000;
            4'd6:    w = 32'd1000;
            4'd7:    w = 32'd100;
            4'd8:    w = 32'd10;
            default: w = 32'd1;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
        logic [7:0] g;
        if (nib < 4'd10) begin
            g = GLYPH_ZERO + {4'd0, nib};
        end else begin
            g = GLYPH_A + {4'd0, nib} - 8'd10;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

/* rtl/tcnf_seq.sv */
`default_nettype none

module tcnf_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tcnf_pkg::tcnf_stat_t stat,
    output tcnf_pkg::tcnf_ctrl_t     ctrl
);
    import tcnf_pkg::*;

    uaddr_t upc_reg;
    uaddr_t upc_next;
    uword_t uw;

    assign uw      = ucode_rom(upc_reg);
    assign ctrl.op = uw.op;

    // A step repeats while the datapath stalls; otherwise its rule picks the next one.
    always_comb begin
        upc_next = upc_reg;
        if (!stat.stall) begin
            case (uw.cond)
                COND_NEXT:     upc_next = upc_reg + 3'd1;
                COND_GOTO:     upc_next = uw.target;
                COND_DISPATCH: upc_next = dispatch(stat.action);
                COND_IF_HEX:   upc_next = stat.is_hex ? uw.target : upc_reg + 3'd1;
                COND_LOOP:     upc_next = stat.done ? uw.target : upc_reg;
                default:       upc_next = UA_FETCH;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/text_cursor_number_formatter.sv */
`default_nettype none
// Text cursor number formatter.
// The input channel (s_valid, s_ready, s_data) takes one word per request: a
// character, a newline, or a 32-bit value to print as signed or unsigned
// decimal or hexadecimal, optionally followed by a newline. The result
// channel (m_valid, m_ready, m_data) gives one draw command per glyph, with
// the cursor position and the ASCII code; the final command of a word has
// last_of_run set. A newline word, and a word with an unused action code,
// gives no command at all.
// A small microcode program steps a shared datapath, one step per cycle
// while it does not stall. A character runs the fetch, character and finish
// steps, a newline the fetch and newline steps, and a value the fetch, sign,
// digit loop and finish steps. Decimal digits come from a loop that subtracts
// one power of ten per cycle. A character, or the minus sign of a negative
// signed value, is emitted in the step after fetch. s_ready is high only
// while the sequencer waits for a new word.
// Commands leave through an output register; while the receiver stalls, the
// step that wants to emit the next glyph holds and the sequencer waits.
// Reset puts the cursor at the top left corner and the sequencer at its
// fetch step, with no command pending.
module text_cursor_number_formatter #(
    parameter int LINE_WIDTH  = 512,
    parameter int GLYPH_WIDTH = 8,
    parameter int LINE_HEIGHT = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tcnf_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tcnf_pkg::out_word_t      m_data
);
    import tcnf_pkg::*;

    // The column holds values up to just below LINE_WIDTH + GLYPH_WIDTH before wrapping.
    localparam int COL_W = $clog2(LINE_WIDTH + GLYPH_WIDTH);

    tcnf_ctrl_t ctrl;
    tcnf_stat_t stat;

    // Word held while it is being printed.
    logic [2:0]  action_reg,  action_next;
    logic [7:0]  char_reg,    char_next;
    logic [31:0] value_reg,   value_next;
    logic        nl_reg,      nl_next;
    // Digit position, current decimal digit and whether a digit has been shown yet.
    logic [3:0]  pos_reg,     pos_next;
    logic [3:0]  digit_reg,   digit_next;
    logic        shown_reg,   shown_next;
    // Cursor.
    logic [COL_W-1:0] col_reg, col_next;
    logic [15:0] row_reg,     row_next;
    // Output register.
    logic        m_valid_reg, m_valid_next;
    out_word_t   m_data_reg,  m_data_next;

    logic        out_free;
    logic        is_signed;
    logic        negative;
    logic [31:0] weight;
    logic        dec_ge;
    logic        dec_show;
    logic        emit_en;
    logic [7:0]  emit_glyph;
    logic        emit_last;
    logic        newline_en;
    logic [COL_W-1:0] col_adv;

    tcnf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign is_signed = (action_reg == ACT_SDEC) || (action_reg == ACT_SHEX);
    assign negative  = is_signed && value_reg[31];
    assign weight    = pow10(pos_reg);
    assign dec_ge    = value_reg >= weight;
    // Leading zeros are dropped, but the units digit always prints so that zero shows as '0'.
    assign dec_show  = shown_reg || (digit_reg != 4'd0) || (pos_reg == DEC_LAST_POS);
    assign col_adv   = col_reg + COL_W'(GLYPH_WIDTH);

    assign s_ready = (ctrl.op == OP_FETCH);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Decide what the current step does and whether it has to wait.
    always_comb begin
        stat.stall  = 1'b0;
        stat.done   = 1'b0;
        stat.is_hex = (action_reg == ACT_SHEX) || (action_reg == ACT_UHEX);
        stat.action = s_data.action;
        emit_en     = 1'b0;
        emit_glyph  = GLYPH_ZERO;
        emit_last   = 1'b0;
        newline_en  = 1'b0;

        action_next = action_reg;
        char_next   = char_reg;
        value_next  = value_reg;
        nl_next     = nl_reg;
        pos_next    = pos_reg;
        digit_next  = digit_reg;
        shown_next  = shown_reg;

        unique case (ctrl.op)
            OP_FETCH: begin
                stat.stall = !s_valid;
                if (s_valid) begin
                    action_next = s_data.action;
                    char_next   = s_data.char_code;
                    value_next  = s_data.number_value;
                    nl_next     = s_data.newline_after;
                    pos_next    = 4'd0;
                    digit_next  = 4'd0;
                    shown_next  = 1'b0;
                end
            end
            OP_CHAR: begin
                stat.stall = !out_free;
                emit_en    = out_free;
                emit_glyph = char_reg;
                emit_last  = 1'b1;
            end
            OP_NEWLINE: begin
                newline_en = 1'b1;
            end
            OP_SIGN: begin
                // The most negative value negates to itself and reads as 2147483648.
                stat.stall = negative && !out_free;
                if (negative && out_free) begin
                    emit_en    = 1'b1;
                    emit_glyph = GLYPH_MINUS;
                    value_next = 32'd0 - value_reg;
                end
            end
            OP_DEC: begin
                if (dec_ge) begin
                    value_next = value_reg - weight;
                    digit_next = digit_reg + 4'd1;
                end else begin
                    stat.stall = dec_show && !out_free;
                    stat.done  = (pos_reg == DEC_LAST_POS) && !stat.stall;
                    if (!stat.stall) begin
                        emit_en    = dec_show;
                        emit_glyph = GLYPH_ZERO + {4'd0, digit_reg};
                        emit_last  = (pos_reg == DEC_LAST_POS);
                        shown_next = dec_show;
                        digit_next = 4'd0;
                        pos_next   = pos_reg + 4'd1;
                    end
                end
            end
            OP_HEX: begin
                stat.stall = !out_free;
                stat.done  = (pos_reg == HEX_LAST_POS) && out_free;
                if (out_free) begin
                    emit_en    = 1'b1;
                    emit_glyph = hex_glyph(value_reg[31:28]);
                    emit_last  = (pos_reg == HEX_LAST_POS);
                    value_next = {value_reg[27:0], 4'd0};
                    pos_next   = pos_reg + 4'd1;
                end
            end
            OP_FINISH: begin
                newline_en = nl_reg;
            end
            default: begin
                stat.stall = 1'b0;
            end
        endcase
    end

    // Cursor and output register.
    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (emit_en) begin
            m_valid_next            = 1'b1;
            m_data_next.draw_x      = 9'(col_reg);
            m_data_next.draw_y      = row_reg;
            m_data_next.glyph       = emit_glyph;
            m_data_next.last_of_run = emit_last;
            if (col_adv >= COL_W'(LINE_WIDTH)) begin
                col_next = '0;
                row_next = row_reg + 16'(LINE_HEIGHT);
            end else begin
                col_next = col_adv;
            end
        end else if (newline_en) begin
            col_next = '0;
            row_next = row_reg + 16'(LINE_HEIGHT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
            pos_reg     <= 4'd0;
            digit_reg   <= 4'd0;
            shown_reg   <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
            pos_reg     <= pos_next;
            digit_reg   <= digit_next;
            shown_reg   <= shown_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        char_reg   <= char_next;
        value_reg  <= value_next;
        nl_reg     <= nl_next;
        m_data_reg <= m_data_next;
    end

`include "text_cursor_number_formatter_assert.svh"

    // The cursor never rests at or beyond the right edge.
    `TCNF_ASSERT_ALWAYS(a_col_in_line, col_reg < COL_W'(LINE_WIDTH))
    // The decimal digit position never runs past the units digit.
    `TCNF_ASSERT_ALWAYS(a_dec_pos, (ctrl.op != OP_DEC) || (pos_reg <= DEC_LAST_POS))
    // After the final glyph of a word the program always goes to its closing step.
    `TCNF_ASSERT_NEXT(a_last_then_finish, emit_en && emit_last, ctrl.op == OP_FINISH)

endmodule

`default_nettype wire
